FILE: rtl/hss_pkg.sv
// Shared widths, constants and the sideband type of the haptic sample scaler.
// Used by the top level, the pipelined divider and the port checker.
package hss_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  // magnitude of a sample reaches 2^FRAC_BITS, so it needs all SAMPLE_BITS bits
  localparam int A_W       = SAMPLE_BITS;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;

  localparam int SQ_W  = 2 * A_W;
  localparam int SQ_SH = 2 * FRAC_BITS - 16;
  localparam int Q_W   = 17;
  localparam int SA_W  = A_W + GAIN_W;
  localparam int DP_W  = 32;
  localparam int D_W   = 33;
  localparam int DEN_ONE_SH = 28;
  localparam int M_W   = FRAC_BITS + 4;
  localparam int N_W   = FRAC_BITS + 33;
  localparam int ADJ_W = M_W + 4;

  localparam int PRE_STAGES  = 5;
  localparam int POST_STAGES = 3;
  localparam int PIPE_DEPTH  = PRE_STAGES + M_W + POST_STAGES;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 2;
  localparam int CLIP_W     = 15;

  typedef struct packed {
    logic           neg;
    logic           last;
    logic           knee;
    logic [M_W-1:0] mlin;
    logic [A_W-1:0] mag;
  } hss_side_t;

endpackage

FILE: rtl/hss_div_pipe.sv
// Restoring divider, one quotient bit per register stage, with its own
// valid/ready chain and a sideband that travels with each beat. Uses hss_pkg.
module hss_div_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [hss_pkg::D_W-1:0] in_den_i,
  input  logic [hss_pkg::N_W-1:0] in_num_i,
  input  hss_pkg::hss_side_t     in_side_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [hss_pkg::M_W-1:0] out_quo_o,
  output hss_pkg::hss_side_t     out_side_o
);
  import hss_pkg::*;

  localparam int STEPS    = M_W;
  localparam int REM0_PAD = D_W - (N_W - M_W);

  logic           v_q    [STEPS];
  logic           rdy    [STEPS];
  logic [D_W-1:0] rem_q  [STEPS];
  logic [D_W-1:0] den_q  [STEPS];
  logic [M_W-1:0] word_q [STEPS];
  hss_side_t      side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic           v_prev;
    logic [D_W-1:0] rem_prev;
    logic [D_W-1:0] den_prev;
    logic [M_W-1:0] word_prev;
    hss_side_t      side_prev;
    logic           rdy_next;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_prev    = in_valid_i;
      assign rem_prev  = {REM0_PAD'(0), in_num_i[N_W-1:M_W]};
      assign den_prev  = in_den_i;
      assign word_prev = in_num_i[M_W-1:0];
      assign side_prev = in_side_i;
    end else begin : g_next
      assign v_prev    = v_q[k-1];
      assign rem_prev  = rem_q[k-1];
      assign den_prev  = den_q[k-1];
      assign word_prev = word_q[k-1];
      assign side_prev = side_q[k-1];
    end

    if (k == STEPS - 1) begin : g_tail
      assign rdy_next = out_ready_i;
    end else begin : g_body
      assign rdy_next = rdy[k+1];
    end

    assign rdy[k] = !v_q[k] || rdy_next;

    // bring down the next numerator bit, subtract when it fits
    assign trial = {rem_prev, word_prev[M_W-1]};
    assign diff  = trial - {1'b0, den_prev};
    assign ge    = trial >= {1'b0, den_prev};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_prev) begin
        rem_q[k]  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        den_q[k]  <= den_prev;
        word_q[k] <= {word_prev[M_W-2:0], ge};
        side_q[k] <= side_prev;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[STEPS-1];
  assign out_quo_o   = word_q[STEPS-1];
  assign out_side_o  = side_q[STEPS-1];

endmodule

FILE: rtl/haptic_sample_soft_scaler.sv
// Top level of the haptic sample scaler: config registers, pre-divide and
// post-divide pipeline stages. Depends on hss_pkg and hss_div_pipe.
//
//   channel   direction  handshake                payload
//   --------  ---------  -----------------------  -------------------------------
//   input     in         in_valid_i / in_stall_o  sample_in_i, last_in_i
//   output    out        out_valid_o / out_stall_i sample_out_o, last_out_o
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat enters and one leaves per cycle, sustained, while out_stall_i is low.
// The pipe is 5 pre-divide stages, 19 divider stages (one quotient bit each,
// set by the restoring divider) and 3 post stages for gain, saturation and clip.
// Reset clears every valid bit and loads the config defaults; payload flops
// are not reset. A stall at the output holds each full stage whose successor
// is full; empty stages keep filling, so bubbles squeeze out and no beat is
// lost or repeated. Config writes are always ready and are registered directly.
module haptic_sample_soft_scaler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [hss_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                 last_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [hss_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                 last_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [hss_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [hss_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import hss_pkg::*;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_EN     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_FACTOR = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT   = CFG_IDX_W'(4);

  // mode codes; the unused code behaves as pass
  localparam logic [MODE_W-1:0] MODE_PASS  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_MUTE  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_SCALE = MODE_W'(2);

  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [D_W-1:0]    DEN_ONE   = D_W'(1) << DEN_ONE_SH;
  localparam logic [N_W-1:0]    DEN_HALF  = N_W'(1) << (DEN_ONE_SH - 1);
  localparam logic [SA_W:0]     SA_RND    = (SA_W + 1)'(1) << (GAIN_FRAC - 1);
  localparam logic [M_W+GAIN_W:0] ADJ_RND = (M_W + GAIN_W + 1)'(1) << (GAIN_FRAC - 1);
  localparam logic [ADJ_W-1:0]  POS_MAX   = (ADJ_W'(1) << FRAC_BITS) - ADJ_W'(1);
  localparam logic [ADJ_W-1:0]  NEG_MAX   = ADJ_W'(1) << FRAC_BITS;
  localparam int                CLIP_SH   = FRAC_BITS - 15;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0] mode_q;
  logic [GAIN_W-1:0] scale_q;
  logic              adapt_en_q;
  logic [GAIN_W-1:0] adapt_fac_q;
  logic [CLIP_W-1:0] clip_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_PASS;
      scale_q     <= GAIN_ONE;
      adapt_en_q  <= 1'b0;
      adapt_fac_q <= GAIN_ONE;
      clip_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCALE_MODE:   mode_q      <= cfg_data_i[MODE_W-1:0];
        REG_SCALE_FACTOR: scale_q     <= cfg_data_i[GAIN_W-1:0];
        REG_ADAPT_EN:     adapt_en_q  <= cfg_data_i[0];
        REG_ADAPT_FACTOR: adapt_fac_q <= cfg_data_i[GAIN_W-1:0];
        REG_CLIP_LIMIT:   clip_q      <= cfg_data_i[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake chain: a stage loads when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;
  logic div_in_ready, div_out_valid;

  assign rdy8 = !v8_q || !out_stall_i;
  assign rdy7 = !v7_q || rdy8;
  assign rdy6 = !v6_q || rdy7;
  assign rdy5 = !v5_q || div_in_ready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= div_out_valid;
      if (rdy7) v7_q <= v6_q;
      if (rdy8) v8_q <= v7_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: split into sign and magnitude
  // ---------------------------------------------------------------------------
  logic [A_W-1:0] raw_in;
  logic [A_W-1:0] mag1_d, mag1_q;
  logic           neg1_q, last1_q;

  assign raw_in = sample_in_i;
  assign mag1_d = raw_in[FRAC_BITS] ? (~raw_in + A_W'(1)) : raw_in;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      mag1_q  <= mag1_d;
      neg1_q  <= raw_in[FRAC_BITS];
      last1_q <= last_in_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: square and linear product; decide soft knee or linear
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0] sq2_q;
  logic [SA_W-1:0] sa2_q;
  logic [A_W-1:0]  mag2_q;
  logic            neg2_q, last2_q, knee2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sq2_q   <= SQ_W'(mag1_q) * SQ_W'(mag1_q);
      sa2_q   <= SA_W'(mag1_q) * SA_W'(scale_q);
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      last2_q <= last1_q;
      knee2_q <= (mode_q == MODE_SCALE) && (scale_q > GAIN_ONE) && (mag1_q != '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: x*x to Q1.16, rounded linear result
  // ---------------------------------------------------------------------------
  logic [Q_W-1:0]  q3_d, q3_q;
  logic [SA_W:0]   sa_rnd;
  logic [SA_W-1:0] sa3_q;
  hss_side_t       side3_q;

  if (SQ_SH > 0) begin : g_sq_down
    logic [SQ_W:0] sq_rnd;
    assign sq_rnd = {1'b0, sq2_q} + ((SQ_W + 1)'(1) << (SQ_SH - 1));
    assign q3_d   = Q_W'(sq_rnd >> SQ_SH);
  end else begin : g_sq_up
    assign q3_d = Q_W'(sq2_q) << (-SQ_SH);
  end

  assign sa_rnd = {1'b0, sa2_q} + SA_RND;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      q3_q         <= q3_d;
      sa3_q        <= sa2_q;
      side3_q.neg  <= neg2_q;
      side3_q.last <= last2_q;
      side3_q.knee <= knee2_q;
      side3_q.mlin <= M_W'(sa_rnd >> GAIN_FRAC);
      side3_q.mag  <= mag2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: (S-1)*x*x, zero on the linear path to keep the divider quiet
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]     knee_fac;
  logic [GAIN_W+Q_W-1:0] dp_full;
  logic [DP_W-1:0]       dp4_q;
  logic [SA_W-1:0]       sa4_q;
  hss_side_t             side4_q;

  assign knee_fac = side3_q.knee ? (scale_q - GAIN_ONE) : '0;
  assign dp_full  = (GAIN_W + Q_W)'(knee_fac) * (GAIN_W + Q_W)'(q3_q);

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      dp4_q   <= DP_W'(dp_full);
      sa4_q   <= sa3_q;
      side4_q <= side3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: denominator and numerator with the half-divisor rounding term
  // ---------------------------------------------------------------------------
  logic [D_W-1:0] den5_q;
  logic [N_W-1:0] num5_q;
  hss_side_t      side5_q;

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      den5_q  <= DEN_ONE + D_W'(dp4_q);
      num5_q  <= (N_W'(sa4_q) << 16) + DEN_HALF + N_W'(dp4_q >> 1);
      side5_q <= side4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider
  // ---------------------------------------------------------------------------
  logic [M_W-1:0] div_quo;
  hss_side_t      div_side;

  hss_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .in_ready_o  (div_in_ready),
    .in_den_i    (den5_q),
    .in_num_i    (num5_q),
    .in_side_i   (side5_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (rdy6),
    .out_quo_o   (div_quo),
    .out_side_o  (div_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: pick knee or linear magnitude, multiply by the adaptive gain
  // ---------------------------------------------------------------------------
  logic [M_W-1:0]        msel6_d, msel6_q;
  logic [M_W+GAIN_W-1:0] prod6_q;
  hss_side_t             side6_q;

  assign msel6_d = div_side.knee ? div_quo : div_side.mlin;

  always_ff @(posedge clk_i) begin
    if (rdy6 && div_out_valid) begin
      msel6_q <= msel6_d;
      prod6_q <= (M_W + GAIN_W)'(msel6_d) * (M_W + GAIN_W)'(adapt_fac_q);
      side6_q <= div_side;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: round the gain, saturate, apply the mode
  // ---------------------------------------------------------------------------
  logic [M_W+GAIN_W:0] adj_rnd;
  logic [ADJ_W-1:0]    adj7, cap7, sat7;
  logic [A_W-1:0]      mag7_d, mag7_q;
  logic                neg7_q, last7_q;

  assign adj_rnd = {1'b0, prod6_q} + ADJ_RND;
  assign adj7    = adapt_en_q ? ADJ_W'(adj_rnd >> GAIN_FRAC) : ADJ_W'(msel6_q);
  assign cap7    = side6_q.neg ? NEG_MAX : POS_MAX;
  assign sat7    = (adj7 > cap7) ? cap7 : adj7;

  always_comb begin
    case (mode_q)
      MODE_MUTE:  mag7_d = '0;
      MODE_SCALE: mag7_d = A_W'(sat7);
      default:    mag7_d = side6_q.mag;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy7 && v6_q) begin
      mag7_q  <= mag7_d;
      neg7_q  <= side6_q.neg;
      last7_q <= side6_q.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: clip to the limit, restore the sign into the output register
  // ---------------------------------------------------------------------------
  logic [A_W-1:0]         lim8, clip8;
  logic [SAMPLE_BITS-1:0] sample8_q;
  logic                   last8_q;

  if (CLIP_SH >= 0) begin : g_lim_up
    assign lim8 = A_W'(clip_q) << CLIP_SH;
  end else begin : g_lim_down
    assign lim8 = A_W'(clip_q >> (-CLIP_SH));
  end

  assign clip8 = ((clip_q != '0) && (mag7_q > lim8)) ? lim8 : mag7_q;

  always_ff @(posedge clk_i) begin
    if (rdy8 && v7_q) begin
      sample8_q <= neg7_q ? SAMPLE_BITS'(~clip8 + A_W'(1)) : SAMPLE_BITS'(clip8);
      last8_q   <= last7_q;
    end
  end

  assign out_valid_o  = v8_q;
  assign sample_out_o = sample8_q;
  assign last_out_o   = last8_q;

endmodule

FILE: rtl/hss_chk.sv
// Port-level checker for the haptic sample scaler, bound to the top level.
// Depends on hss_pkg for the pipeline depth.
module hss_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic signed [hss_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input logic                                 last_in_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [hss_pkg::SAMPLE_BITS-1:0] sample_out_o,
  input logic                                 last_out_o
);
  import hss_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             in_beat, out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // track beats in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case ({in_beat, out_beat})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

  // input only backs up behind a stalled, full output register
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output was free");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(sample_in_i) && $stable(last_in_i)))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(sample_out_o) && $stable(last_out_o)))
    else $error("stalled output beat changed");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0))
    else $error("output beat with nothing in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_DEPTH))
    else $error("more beats in flight than pipeline stages");

endmodule

bind haptic_sample_soft_scaler hss_chk u_hss_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .sample_in_i  (sample_in_i),
  .last_in_i    (last_in_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .sample_out_o (sample_out_o),
  .last_out_o   (last_out_o)
);
